>>> hdl/aws_pkg.sv
// Shared types and constants for the Ackermann wheel steering angle pipeline.
`default_nettype none

package aws_pkg;

  localparam int ROT_W = 33;
  localparam int VEC_W = 54;
  localparam int ANG_W = 33;
  localparam int TABLE_LEN = 24;

  localparam logic [1:0] REG_TRACK = 2'd0;
  localparam logic [1:0] REG_BASE  = 2'd1;
  localparam logic [1:0] REG_MAX   = 2'd2;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic [63:0] STEER_LIMIT_Q32 = 64'd6703569179;

  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128
  };

  typedef struct packed {
    logic                    negcmd;
    logic                    zero;
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } rot_t;

  typedef struct packed {
    logic                    negcmd;
    logic                    zero;
    logic                    xz_o;
    logic                    neg_o;
    logic                    xz_i;
    logic                    neg_i;
    logic signed [VEC_W-1:0] xo;
    logic signed [VEC_W-1:0] yo;
    logic signed [ANG_W-1:0] zo;
    logic signed [VEC_W-1:0] xi;
    logic signed [VEC_W-1:0] yi;
    logic signed [ANG_W-1:0] zi;
  } vec_t;

endpackage

`default_nettype wire

>>> hdl/ackermann_wheel_steer_angles.sv
// Stages: seed, rotation cells, products, vectoring seed, vectoring cells, output.
// Throughput: one item per cycle; every CORDIC stage is a cell of its own.
// The whole pipeline holds while a finished result waits under out_stall.
// Reset clears all valid bits and loads the configuration reset values.
// Sine/cosine come from a rotation chain, both wheel angles from a vectoring chain.
`default_nettype none

module ackermann_wheel_steer_angles import aws_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 14,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] steer_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] left_wheel_yaw,
  output logic signed [15:0] right_wheel_yaw
);

  localparam int ZSH = 30 - ANGLE_FRAC_BITS;
  localparam logic [31:0] LIM = 32'(STEER_LIMIT_Q32 >> (32 - ANGLE_FRAC_BITS));

  logic [15:0] track_width_mm;
  logic [15:0] wheelbase_mm;
  logic [14:0] max_steer_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_width_mm  <= 16'd1800;
      wheelbase_mm    <= 16'd1300;
      max_steer_angle <= 15'd8579;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRACK: track_width_mm  <= cfg_data;
        REG_BASE:  wheelbase_mm    <= cfg_data;
        REG_MAX:   max_steer_angle <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Front end: magnitude, clamp, seed the rotation
  logic        negcmd;
  logic [16:0] mag;
  logic [31:0] clampv;
  logic [31:0] magc;
  logic [63:0] zseed;
  rot_t        seed;

  always_comb begin
    negcmd = steer_angle[15];
    mag    = negcmd ? (17'h10000 - {1'b0, steer_angle}) : {1'b0, steer_angle};
    clampv = ({17'd0, max_steer_angle} < LIM) ? {17'd0, max_steer_angle} : LIM;
    magc   = ({15'd0, mag} > clampv) ? clampv : {15'd0, mag};
    zseed  = {32'd0, magc} << ZSH;
    seed.negcmd = negcmd;
    seed.zero   = (magc == 32'd0);
    seed.x      = $signed(ROT_W'(64'd1 << 30));
    seed.y      = '0;
    seed.z      = $signed(zseed[ANG_W-1:0]);
  end

  logic rv [CORDIC_STAGES+1];
  rot_t rs [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs[0] <= seed;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    aws_rot_cell #(.STAGE(g)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .d_valid(rv[g]), .d(rs[g]), .q_valid(rv[g+1]), .q(rs[g+1])
    );
  end

  // Products
  logic                    pv;
  logic                    p_negcmd;
  logic                    p_zero;
  logic signed [VEC_W-1:0] p_num;
  logic signed [VEC_W-1:0] p_lx;
  logic signed [VEC_W-1:0] p_wy;
  logic signed [17:0]      two_l;
  logic signed [17:0]      w_s;

  assign two_l = $signed({1'b0, wheelbase_mm, 1'b0});
  assign w_s   = $signed({2'b0, track_width_mm});

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= rv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_negcmd <= rs[CORDIC_STAGES].negcmd;
      p_zero   <= rs[CORDIC_STAGES].zero || (rs[CORDIC_STAGES].y <= 0);
      p_num    <= VEC_W'(two_l) * VEC_W'(rs[CORDIC_STAGES].y);
      p_lx     <= VEC_W'(two_l) * VEC_W'(rs[CORDIC_STAGES].x);
      p_wy     <= VEC_W'(w_s) * VEC_W'(rs[CORDIC_STAGES].y);
    end
  end

  // Denominators and vectoring seed
  logic signed [VEC_W-1:0] den_o;
  logic signed [VEC_W-1:0] den_i;
  vec_t                    vseed;

  always_comb begin
    den_o = p_lx + p_wy;
    den_i = p_lx - p_wy;
    vseed.negcmd = p_negcmd;
    vseed.zero   = p_zero || (p_num == '0);
    vseed.xz_o   = (den_o == '0);
    vseed.neg_o  = den_o < 0;
    vseed.xz_i   = (den_i == '0);
    vseed.neg_i  = den_i < 0;
    vseed.xo     = (den_o < 0) ? -den_o : den_o;
    vseed.yo     = p_num;
    vseed.zo     = '0;
    vseed.xi     = (den_i < 0) ? -den_i : den_i;
    vseed.yi     = p_num;
    vseed.zi     = '0;
  end

  logic vv [CORDIC_STAGES+1];
  vec_t vs [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (en) begin
      vv[0] <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vs[0] <= vseed;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
    aws_vec_cell #(.STAGE(g)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .d_valid(vv[g]), .d(vs[g]), .q_valid(vv[g+1]), .q(vs[g+1])
    );
  end

  // Clamp, round and sign one wheel angle
  function automatic logic [15:0] wheel_out(input logic signed [ANG_W-1:0] z,
                                            input logic xz, input logic neg,
                                            input logic ncmd);
    logic [ANG_W-1:0] m;
    logic [ANG_W:0]   qs;
    logic [14:0]      q;
    logic             sgn;
    if (xz) m = HALF_PI_Q30;
    else if (z < 0) m = '0;
    else if (z > HALF_PI_Q30) m = HALF_PI_Q30;
    else m = z;
    sgn = (neg && !xz && (m != '0)) ^ ncmd;
    qs  = ({1'b0, m} + (ANG_W+1)'(64'd1 << (ZSH - 1))) >> ZSH;
    q   = (qs > (ANG_W+1)'(32767)) ? 15'h7fff : qs[14:0];
    return sgn ? 16'(-{1'b0, q}) : {1'b0, q};
  endfunction

  logic [15:0] ang_o;
  logic [15:0] ang_i;
  vec_t        vf;

  assign vf    = vs[CORDIC_STAGES];
  assign ang_o = wheel_out(vf.zo, vf.xz_o, vf.neg_o, vf.negcmd);
  assign ang_i = wheel_out(vf.zi, vf.xz_i, vf.neg_i, vf.negcmd);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vv[CORDIC_STAGES];
    end
  end

  // Inner wheel is left for a left turn
  always_ff @(posedge clk) begin
    if (en) begin
      if (vf.zero) begin
        left_wheel_yaw  <= '0;
        right_wheel_yaw <= '0;
      end else if (!vf.negcmd) begin
        left_wheel_yaw  <= $signed(ang_i);
        right_wheel_yaw <= $signed(ang_o);
      end else begin
        left_wheel_yaw  <= $signed(ang_o);
        right_wheel_yaw <= $signed(ang_i);
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_wheel_yaw <= 16'sd25736 && left_wheel_yaw >= -16'sd25736 &&
                   right_wheel_yaw <= 16'sd25736 && right_wheel_yaw >= -16'sd25736))
    else $error("wheel yaw beyond a quarter turn");

  a_same_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && left_wheel_yaw > 0 |-> right_wheel_yaw >= 0)
    else $error("wheel yaws of opposite sign");

endmodule

`default_nettype wire

>>> hdl/aws_rot_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation, registered.
`default_nettype none

module aws_rot_cell import aws_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic d_valid,
  input  rot_t d,
  output logic q_valid,
  output rot_t q
);

  logic signed [ROT_W-1:0] xs;
  logic signed [ROT_W-1:0] ys;
  logic signed [ANG_W-1:0] a;
  rot_t nx;

  always_comb begin
    nx = d;
    xs = d.x >>> STAGE;
    ys = d.y >>> STAGE;
    a  = $signed({1'b0, ATAN_Q30[STAGE]});
    if (d.z >= 0) begin
      nx.x = d.x - ys;
      nx.y = d.y + xs;
      nx.z = d.z - a;
    end else begin
      nx.x = d.x + ys;
      nx.y = d.y - xs;
      nx.z = d.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nx;
    end
  end

endmodule

`default_nettype wire

>>> hdl/aws_vec_cell.sv
// One vectoring-mode CORDIC cell for both wheel lanes, registered.
`default_nettype none

module aws_vec_cell import aws_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic d_valid,
  input  vec_t d,
  output logic q_valid,
  output vec_t q
);

  logic signed [ANG_W-1:0] a;
  vec_t nx;

  always_comb begin
    nx = d;
    a  = $signed({1'b0, ATAN_Q30[STAGE]});
    if (d.yo >= 0) begin
      nx.xo = d.xo + (d.yo >>> STAGE);
      nx.yo = d.yo - (d.xo >>> STAGE);
      nx.zo = d.zo + a;
    end else begin
      nx.xo = d.xo - (d.yo >>> STAGE);
      nx.yo = d.yo + (d.xo >>> STAGE);
      nx.zo = d.zo - a;
    end
    if (d.yi >= 0) begin
      nx.xi = d.xi + (d.yi >>> STAGE);
      nx.yi = d.yi - (d.xi >>> STAGE);
      nx.zi = d.zi + a;
    end else begin
      nx.xi = d.xi - (d.yi >>> STAGE);
      nx.yi = d.yi + (d.xi >>> STAGE);
      nx.zi = d.zi - a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nx;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_ackermann_wheel_steer_angles.sv
// Testbench for the Ackermann wheel steering angle pipeline against an in-bench model.
`timescale 1ns / 100ps

module tb_ackermann_wheel_steer_angles import aws_pkg::*; ();

  localparam int FRAC = 14;
  localparam int STAGES = 16;
  localparam int PIPE_LAT = 2 * STAGES + 4;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct {
    logic signed [15:0] left_yaw;
    logic signed [15:0] right_yaw;
  } yaw_pair_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] steer_angle;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] left_wheel_yaw;
  logic signed [15:0] right_wheel_yaw;

  ackermann_wheel_steer_angles u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .steer_angle(steer_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_wheel_yaw(left_wheel_yaw), .right_wheel_yaw(right_wheel_yaw)
  );

  logic [15:0] track_mm;
  logic [15:0] wbase_mm;
  logic [14:0] max_ang;

  logic signed [15:0] cmd_queue[$];
  yaw_pair_t yaw_expected[$];
  int errors;
  int burst_left;
  int gap_left;
  int stall_phase;
  bit drive_on;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint steer_atan(longint den, longint num);
    bit neg;
    longint x, y, z, xs, ys;
    neg = den < 0;
    x = neg ? -den : den;
    y = num;
    z = 0;
    if (x == 0) return longint'(HALF_PI_Q30);
    for (int i = 0; i < STAGES; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
    return neg ? -z : z;
  endfunction

  function automatic logic [15:0] yaw_q14(longint z, bit negcmd);
    bit neg;
    longint m, q;
    neg = (z < 0) != negcmd;
    m = z < 0 ? -z : z;
    q = (m + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    if (q > 32767) q = 32767;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  function automatic yaw_pair_t wheel_yaws(logic signed [15:0] cmd);
    yaw_pair_t r;
    bit negcmd;
    longint mag, lim, clampv, x, y, z, xs, ys, two_l, num, ang_o, ang_i;
    negcmd = cmd[15];
    mag = negcmd ? 65536 - longint'({16'd0, cmd}) : longint'(cmd);
    lim = longint'(STEER_LIMIT_Q32 >> (32 - FRAC));
    clampv = max_ang < lim ? longint'(max_ang) : lim;
    if (mag > clampv) mag = clampv;
    r.left_yaw = '0;
    r.right_yaw = '0;
    if (mag == 0) return r;
    x = longint'(1) << 30;
    y = 0;
    z = mag << (30 - FRAC);
    for (int i = 0; i < STAGES; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
      end
    end
    if (y <= 0) return r;
    two_l = 2 * longint'(wbase_mm);
    num = two_l * y;
    if (num == 0) return r;
    ang_o = steer_atan(two_l * x + longint'(track_mm) * y, num);
    ang_i = steer_atan(two_l * x - longint'(track_mm) * y, num);
    if (!negcmd) begin
      r.left_yaw = yaw_q14(ang_i, 1'b0);
      r.right_yaw = yaw_q14(ang_o, 1'b0);
    end else begin
      r.left_yaw = yaw_q14(ang_o, 1'b1);
      r.right_yaw = yaw_q14(ang_i, 1'b1);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: bursts of items with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        yaw_expected.insert(yaw_expected.size(), wheel_yaws(steer_angle));
      end
      if (!in_valid || !in_stall) begin
        if (drive_on && cmd_queue.size() > 0 && gap_left == 0) begin
          in_valid <= 1'b1;
          steer_angle <= cmd_queue.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // Monitor: check each result, then pick the next stall value.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (yaw_expected.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          yaw_pair_t e;
          e = yaw_expected.pop_front();
          if (left_wheel_yaw !== e.left_yaw)
            report_mismatch("left_wheel_yaw", left_wheel_yaw, e.left_yaw);
          if (right_wheel_yaw !== e.right_yaw)
            report_mismatch("right_wheel_yaw", right_wheel_yaw, e.right_yaw);
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 40) out_stall <= 1'b0;
      else if (stall_phase < 70) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TRACK) track_mm = val;
    else if (idx == REG_BASE) wbase_mm = val;
    else if (idx == REG_MAX) max_ang = val[14:0];
    @(posedge clk);
  endtask

  // Release the items in the queue and wait for every result.
  task automatic run_phase();
    drive_on = 1'b1;
    while (cmd_queue.size() > 0 || in_valid) @(negedge clk);
    drive_on = 1'b0;
    while (yaw_expected.size() > 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: cmd_queue.insert(cmd_queue.size(), 16'($urandom_range(0, 65535)));
        1: cmd_queue.insert(cmd_queue.size(), 16'sd0 - 16'($urandom_range(0, 64)));
        2: cmd_queue.insert(cmd_queue.size(), 16'($urandom_range(0, 64)));
        default: cmd_queue.insert(cmd_queue.size(),
                                  16'($urandom_range(0, 2 * 9000)) - 16'sd9000);
      endcase
    end
  endtask

  initial begin
    errors = 0;
    drive_on = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TRACK;
    cfg_data = '0;
    in_valid = 1'b0;
    steer_angle = '0;
    out_stall = 1'b0;
    track_mm = 16'd1800;
    wbase_mm = 16'd1300;
    max_ang = 15'd8579;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, extremes, tiny angles, the clamp edges.
    cmd_queue = '{16'sd0, 16'sd1, -16'sd1, 16'sd2, 16'sd32767, -16'sd32768, -16'sd32767,
                  16'sd8578, 16'sd8579, 16'sd8580, -16'sd8579, 16'sd4096, -16'sd4096,
                  16'sh5555, 16'shAAAA, 16'sd100, -16'sd100};
    run_phase();

    // Wide track, short wheelbase: inner cotangent goes zero and negative.
    write_reg(REG_TRACK, 16'hFFFF);
    write_reg(REG_BASE, 16'd1);
    write_reg(REG_MAX, 16'h7FFF);
    cmd_queue = '{16'sd25408, -16'sd25408, 16'sd32767, -16'sd32768, 16'sd1, 16'sd16};
    add_random(120);
    run_phase();

    write_reg(REG_TRACK, 16'd2000);
    write_reg(REG_BASE, 16'd1000);
    run_phase();
    cmd_queue = '{16'sd5000, -16'sd5000, 16'sd9000};
    add_random(20);
    run_phase();

    // Unknown index is ignored.
    write_reg(REG_NONE, 16'hFFFF);
    write_reg(REG_TRACK, 16'd1);
    write_reg(REG_BASE, 16'hFFFF);
    write_reg(REG_MAX, 16'd0);
    add_random(30);
    run_phase();

    write_reg(REG_MAX, 16'd1);
    add_random(30);
    run_phase();

    write_reg(REG_TRACK, 16'd1800);
    write_reg(REG_BASE, 16'd1300);
    write_reg(REG_MAX, 16'd8579);
    add_random(220);
    run_phase();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_TRACK, 16'($urandom_range(1, 65535)));
      write_reg(REG_BASE, 16'($urandom_range(1, 65535)));
      write_reg(REG_MAX, 16'($urandom_range(0, 32767)));
      add_random(70);
      run_phase();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
